// ===== src/fpl_pkg.sv =====
// ---------------------------------------------------------------------------
// Four-pole ladder low-pass package
// Shared widths, register indexes, fixed-point formats and the tanh table.
// ---------------------------------------------------------------------------
package fpl_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int CUTOFF_W    = 16;
	localparam int FEEDBACK_W  = 15;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF_GAIN   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_GAIN = 1'b1;

	localparam logic [CUTOFF_W-1:0]   CUTOFF_RESET   = 16'd8192;
	localparam logic [FEEDBACK_W-1:0] FEEDBACK_RESET = 15'd0;
	localparam logic [FEEDBACK_W-1:0] FEEDBACK_MAX   = 15'd17203;

	localparam int STAGE_COUNT = 4;
	localparam int STAGE_W     = 24;
	localparam int STG_W       = $clog2(STAGE_COUNT);

	localparam int IN_SHIFT  = 7;
	localparam int OUT_SHIFT = 7;
	localparam int K_FRAC_W  = 12;
	localparam int G_FRAC_W  = 16;

	localparam int TANH_DEPTH     = 256;
	localparam int TANH_LOG2      = $clog2(TANH_DEPTH);
	localparam int TANH_ENTRY_W   = 23;
	localparam int ARG_LIMIT_LSB  = 24;
	localparam int TANH_FRAC_W    = ARG_LIMIT_LSB - TANH_LOG2;
	localparam int TARG_W         = 27;
	localparam logic [31:0] EXP_M1_Q32 = 32'd1580030169;

	localparam int MUL_DIGIT_W = 4;
	localparam int MUL_MR_RAW  = (TANH_FRAC_W > CUTOFF_W) ? TANH_FRAC_W : CUTOFF_W;
	localparam int MUL_MR_W    = ((MUL_MR_RAW + MUL_DIGIT_W - 1) / MUL_DIGIT_W) * MUL_DIGIT_W;
	localparam int MUL_DIGITS  = MUL_MR_W / MUL_DIGIT_W;
	localparam int MUL_MC_W    = STAGE_W + 1;
	localparam int MUL_P_W     = MUL_MR_W + MUL_MC_W;

	typedef logic [TANH_ENTRY_W-1:0] tanh_tab_t [TANH_DEPTH+1];

	// Restoring division, used only while the table is built.
	function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r    = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry i is tanh(4i/depth) in Q1.22, built from e^-u in Q0.32.
	function automatic tanh_tab_t build_tanh_table();
		tanh_tab_t   tab;
		logic [63:0] one;
		logic [63:0] u;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] ef;
		logic [63:0] term;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] den;
		logic [63:0] num;
		one = 64'd1 << 32;
		for (int i = 0; i <= TANH_DEPTH; i++) begin
			u    = ((64'(i) * 64'd8) << 32) >> TANH_LOG2;
			n    = u >> 32;
			f    = u & 64'h0000_0000_FFFF_FFFF;
			ef   = one;
			term = one;
			for (int k = 1; k <= 20; k++) begin
				term = udiv64((term * f) >> 32, 64'(k));
				ef   = ef + term;
			end
			p = one;
			for (int j = 0; j < 8; j++) begin
				if (64'(j) < n) begin
					p = (p * 64'(EXP_M1_Q32)) >> 32;
				end
			end
			q      = udiv64(64'hFFFF_FFFF_FFFF_FFFF, ef);
			p      = (p * q) >> 32;
			den    = one + p;
			num    = ((one - p) << 22) + (den >> 1);
			tab[i] = TANH_ENTRY_W'(udiv64(num, den));
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TABLE = build_tanh_table();

endpackage

// ===== src/fpl_in_if.sv =====
// ---------------------------------------------------------------------------
// Input sample channel
// Valid/ready channel carrying one Q1.15 audio sample per transaction.
// ---------------------------------------------------------------------------
interface fpl_in_if
	import fpl_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] in_sample;

	modport source (output valid, output in_sample, input ready);
	modport sink (input valid, input in_sample, output ready);
endinterface

// ===== src/fpl_out_if.sv =====
// ---------------------------------------------------------------------------
// Output sample channel
// Valid/ready channel carrying one filtered Q1.15 sample per transaction.
// ---------------------------------------------------------------------------
interface fpl_out_if
	import fpl_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink (input valid, input out_sample, output ready);
endinterface

// ===== src/four_pole_ladder_lowpass.sv =====
// ---------------------------------------------------------------------------
// Four-pole ladder low-pass filter
// Each tanh whose argument magnitude is 4.0 or more skips its multiply, and a
// result still held in the output register delays the next one until it is
// taken. A new transaction is taken in the cycle after the result is
// registered, so only one sample is in flight at a time; its products, up to
// eight, go through one 4-bit digit-serial multiplier. Reset clears the
// stages and loads the register defaults; there is no clearing pass.
// ---------------------------------------------------------------------------
module four_pole_ladder_lowpass
	import fpl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	fpl_in_if.sink                 in_if,
	fpl_out_if.source              out_if,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TSET,
		S_TWAIT,
		S_TRET,
		S_FB,
		S_SSET,
		S_SWAIT,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_IN,
		PH_MID,
		PH_OUT
	} phase_t;

	localparam logic signed [MUL_P_W-1:0] FB_HALF   = MUL_P_W'(1) <<< (K_FRAC_W - 1);
	localparam logic signed [MUL_P_W-1:0] G_HALF    = MUL_P_W'(1) <<< (G_FRAC_W - 1);
	localparam logic signed [MUL_P_W-1:0] STAGE_MAX = (MUL_P_W'(1) <<< (STAGE_W - 1)) - 1;
	localparam logic signed [MUL_P_W-1:0] STAGE_MIN = -(MUL_P_W'(1) <<< (STAGE_W - 1));
	localparam logic signed [STAGE_W:0]   OUT_HALF  = (STAGE_W+1)'(1) <<< (OUT_SHIFT - 1);
	localparam logic signed [STAGE_W:0]   Y_MAX     = (STAGE_W+1)'(32767);
	localparam logic signed [STAGE_W:0]   Y_MIN     = -(STAGE_W+1)'(32768);

	state_t                      state_q;
	phase_t                      phase_q;
	logic [STG_W-1:0]            stg_q;
	logic signed [STAGE_W-1:0]   z_q [STAGE_COUNT];
	logic signed [TARG_W-1:0]    arg_q;
	logic signed [STAGE_W-1:0]   tres_q;
	logic [TANH_ENTRY_W-1:0]     lo_q;
	logic                        neg_q;
	logic                        out_valid_q;
	logic signed [SAMPLE_W-1:0]  out_sample_q;
	logic [CUTOFF_W-1:0]         cutoff_q;
	logic [FEEDBACK_W-1:0]       feedback_q;

	logic                        mul_start;
	logic [MUL_MR_W-1:0]         mul_mr;
	logic signed [MUL_MC_W-1:0]  mul_mc;
	logic                        mul_done;
	logic signed [MUL_P_W-1:0]   mul_prod;

	logic                        neg;
	logic [TARG_W-1:0]           mag;
	logic                        big;
	logic [TANH_LOG2-1:0]        idx;
	logic [TANH_LOG2:0]          idx_p1;
	logic [TANH_ENTRY_W-1:0]     lo;
	logic [TANH_ENTRY_W-1:0]     hi;
	logic [TANH_ENTRY_W-1:0]     d;
	logic [TANH_FRAC_W-1:0]      frac;
	logic signed [STAGE_W-1:0]   big_res;
	logic [STAGE_W-1:0]          interp;
	logic signed [STAGE_W-1:0]   interp_res;
	logic signed [MUL_P_W-1:0]   fb_arg;
	logic signed [MUL_MC_W-1:0]  diff;
	logic signed [MUL_P_W-1:0]   zsum;
	logic signed [STAGE_W-1:0]   znew;
	logic signed [STAGE_W:0]     yr;
	logic signed [SAMPLE_W-1:0]  ysat;
	logic                        out_free;

	fpl_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mr     (mul_mr),
		.mc     (mul_mc),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_comb begin
		neg     = arg_q[TARG_W-1];
		mag     = neg ? TARG_W'(-arg_q) : TARG_W'(arg_q);
		big     = |mag[TARG_W-1:ARG_LIMIT_LSB];
		idx     = mag[ARG_LIMIT_LSB-1 -: TANH_LOG2];
		idx_p1  = {1'b0, idx} + {{TANH_LOG2{1'b0}}, 1'b1};
		lo      = TANH_TABLE[idx];
		hi      = TANH_TABLE[idx_p1];
		d       = (hi >= lo) ? (hi - lo) : '0;
		frac    = mag[TANH_FRAC_W-1:0];
		big_res = neg ? -STAGE_W'(TANH_TABLE[TANH_DEPTH]) : STAGE_W'(TANH_TABLE[TANH_DEPTH]);

		interp     = STAGE_W'(lo_q) + mul_prod[TANH_FRAC_W +: STAGE_W];
		interp_res = neg_q ? -interp : interp;

		fb_arg = MUL_P_W'(tres_q) - ((mul_prod + FB_HALF) >>> K_FRAC_W);

		diff = MUL_MC_W'(tres_q) - MUL_MC_W'(z_q[0]);
		zsum = MUL_P_W'(z_q[0]) + ((mul_prod + G_HALF) >>> G_FRAC_W);
		if (zsum > STAGE_MAX) begin
			znew = STAGE_MAX[STAGE_W-1:0];
		end else if (zsum < STAGE_MIN) begin
			znew = STAGE_MIN[STAGE_W-1:0];
		end else begin
			znew = zsum[STAGE_W-1:0];
		end

		yr = ((STAGE_W+1)'(tres_q) + OUT_HALF) >>> OUT_SHIFT;
		if (yr > Y_MAX) begin
			ysat = Y_MAX[SAMPLE_W-1:0];
		end else if (yr < Y_MIN) begin
			ysat = Y_MIN[SAMPLE_W-1:0];
		end else begin
			ysat = yr[SAMPLE_W-1:0];
		end

		out_free = !out_valid_q || out_if.ready;
	end

	always_comb begin
		mul_start = 1'b0;
		mul_mr    = MUL_MR_W'(frac);
		mul_mc    = MUL_MC_W'(d);
		case (state_q)
			S_TSET: begin
				mul_start = !big;
			end
			S_TRET: begin
				if (phase_q == PH_IN) begin
					mul_start = 1'b1;
					mul_mr    = MUL_MR_W'(feedback_q);
					mul_mc    = MUL_MC_W'(z_q[STAGE_COUNT-1]);
				end
			end
			S_SSET: begin
				mul_start = 1'b1;
				mul_mr    = MUL_MR_W'(cutoff_q);
				mul_mc    = diff;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q   <= CUTOFF_RESET;
			feedback_q <= FEEDBACK_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_CUTOFF_GAIN: begin
					cutoff_q <= cfg_data[CUTOFF_W-1:0];
				end
				CFG_FEEDBACK_GAIN: begin
					feedback_q <= (cfg_data[FEEDBACK_W-1:0] > FEEDBACK_MAX) ?
						FEEDBACK_MAX : cfg_data[FEEDBACK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_IN;
			stg_q        <= '0;
			arg_q        <= '0;
			tres_q       <= '0;
			lo_q         <= '0;
			neg_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			for (int i = 0; i < STAGE_COUNT; i++) begin
				z_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_if.ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_if.valid) begin
						arg_q   <= TARG_W'(in_if.in_sample) <<< IN_SHIFT;
						phase_q <= PH_IN;
						state_q <= S_TSET;
					end
				end
				S_TSET: begin
					lo_q  <= lo;
					neg_q <= neg;
					if (big) begin
						tres_q  <= big_res;
						state_q <= S_TRET;
					end else begin
						state_q <= S_TWAIT;
					end
				end
				S_TWAIT: begin
					if (mul_done) begin
						tres_q  <= interp_res;
						state_q <= S_TRET;
					end
				end
				S_TRET: begin
					case (phase_q)
						PH_IN: begin
							state_q <= S_FB;
						end
						PH_MID: begin
							stg_q   <= '0;
							state_q <= S_SSET;
						end
						PH_OUT: begin
							state_q <= S_OUT;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_FB: begin
					if (mul_done) begin
						arg_q   <= fb_arg[TARG_W-1:0];
						phase_q <= PH_MID;
						state_q <= S_TSET;
					end
				end
				S_SSET: begin
					state_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (mul_done) begin
						tres_q <= znew;
						for (int i = 0; i < STAGE_COUNT - 1; i++) begin
							z_q[i] <= z_q[i+1];
						end
						z_q[STAGE_COUNT-1] <= znew;
						if (stg_q == STG_W'(STAGE_COUNT - 1)) begin
							arg_q   <= TARG_W'(znew);
							phase_q <= PH_OUT;
							state_q <= S_TSET;
						end else begin
							stg_q   <= stg_q + 1'b1;
							state_q <= S_SSET;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= ysat;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_if.ready       = (state_q == S_IDLE);
	assign out_if.valid      = out_valid_q;
	assign out_if.out_sample = out_sample_q;

endmodule

// ===== src/fpl_mul.sv =====
// ---------------------------------------------------------------------------
// Digit-serial multiplier
// Unsigned multiplier times signed multiplicand, four bits of the multiplier
// per cycle, most significant digit first; done pulses with the product.
// ---------------------------------------------------------------------------
module fpl_mul
	import fpl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [MUL_MR_W-1:0]        mr,
	input  logic signed [MUL_MC_W-1:0] mc,
	output logic                       done,
	output logic signed [MUL_P_W-1:0]  prod
);

	localparam int CNT_W = $clog2(MUL_DIGITS + 1);

	logic [CNT_W-1:0]                  cnt_q;
	logic                              done_q;
	logic [MUL_MR_W-1:0]               mr_q;
	logic signed [MUL_MC_W-1:0]        mc_q;
	logic signed [MUL_P_W-1:0]         acc_q;
	logic signed [MUL_MC_W+MUL_DIGIT_W:0] pp;

	always_comb begin
		pp = mc_q * $signed({1'b0, mr_q[MUL_MR_W-1 -: MUL_DIGIT_W]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(MUL_DIGITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mr_q  <= mr;
			mc_q  <= mc;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= (acc_q <<< MUL_DIGIT_W) + MUL_P_W'(pp);
			mr_q  <= mr_q << MUL_DIGIT_W;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
